// File: hdl/bpba_pkg.sv
package bpba_pkg;

   localparam int NUM_BLOCKS_DEF = 256;
   localparam int ADDR_W         = 32;
   localparam int OFF_W          = 17;
   localparam int HDR_W          = 8;
   localparam int TICKET_W       = 8;
   localparam int SIZE_W         = 16;
   localparam int OP_W           = 2;
   localparam int ST_W           = 2;
   localparam int CSR_ADDR_W     = 2;

   localparam logic [ADDR_W-1:0] POOL_BASE_RST  = 32'd0;
   localparam logic [OFF_W-1:0]  BLOCK_SIZE_RST = 17'd4096;
   localparam logic [HDR_W-1:0]  HEADER_RST     = 8'd32;

   localparam logic [OP_W-1:0] OP_TAKE   = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
   localparam logic [OP_W-1:0] OP_RETURN = 2'd2;
   localparam logic [OP_W-1:0] OP_REFILL = 2'd3;

   localparam logic [ST_W-1:0] ST_OK  = 2'd0;
   localparam logic [ST_W-1:0] ST_OOM = 2'd1;
   localparam logic [ST_W-1:0] ST_BIG = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_POOL_BASE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLOCK_SIZE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER     = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH,
      S_TK_LOAD, S_TK_MUL, S_TK_ADD, S_TK_RES,
      S_AL_LOAD, S_A_MUL, S_A_ADD, S_A_REM, S_A_WAIT, S_A_CHECK, S_AL_FRESH,
      S_RT_INIT, S_RT_CHECK, S_RT_STEP,
      S_RF_RES, S_FIN
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LATCH, CMD_CLR_INIT, CMD_CLR_STEP,
      CMD_TAKE, CMD_LOAD_CUR, CMD_MUL, CMD_ADD, CMD_REM_START, CMD_PAD,
      CMD_FRESH_LOAD, CMD_BUMP, CMD_FRESH,
      CMD_RES_CLEAR, CMD_RES_OOM, CMD_RES_OOM_CUR, CMD_RES_BIG, CMD_TAKE_RES,
      CMD_WALK_INIT, CMD_WALK_STEP, CMD_RES_RET, CMD_EMIT
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            fc_zero;
      logic            ticket_ok;
      logic            rem_done;
      logic            fits_cur;
      logic            fits_fresh;
      logic            walk_done;
      logic            clr_last;
      logic            out_busy;
   } dp_status_type;

endpackage

// File: hdl/bpba_ram.sv
module bpba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bpba_rem.sv
module bpba_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] remainder
);

   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] r_ff, r_in;
   logic [31:0] q_ff, q_in;
   logic [16:0] trial;

   always_comb begin
      trial  = {r_ff, q_ff[31]};
      cnt_in = cnt_ff;
      r_in   = r_ff;
      q_in   = q_ff;
      if (start) begin
         cnt_in = 6'd32;
         r_in   = 16'd0;
         q_in   = dividend;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         q_in   = {q_ff[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            r_in = 16'(trial - {1'b0, divisor});
         end else begin
            r_in = 16'(trial);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      r_ff <= r_in;
      q_ff <= q_in;
   end

   assign done      = (cnt_ff == 6'd0);
   assign remainder = r_ff;

endmodule

// File: hdl/bpba_dp.sv
module bpba_dp #(
   parameter int NUM_BLOCKS = bpba_pkg::NUM_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bpba_pkg::dp_cmd_type                cmd,
   output bpba_pkg::dp_status_type             status,
   input  logic [bpba_pkg::OP_W-1:0]           req_op,
   input  logic [bpba_pkg::TICKET_W-1:0]       req_ticket,
   input  logic [bpba_pkg::SIZE_W-1:0]         req_size,
   input  logic [bpba_pkg::SIZE_W-1:0]         req_align,
   input  logic                                csr_we,
   input  logic [bpba_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bpba_pkg::ADDR_W-1:0]         csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bpba_pkg::ADDR_W-1:0]         rsp_address,
   output logic [bpba_pkg::TICKET_W-1:0]       rsp_handle,
   output logic [bpba_pkg::ST_W-1:0]           rsp_status
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int OFF_W = bpba_pkg::OFF_W;
   localparam int TBL_W = IDX_W + OFF_W;

   logic [bpba_pkg::OP_W-1:0]     op_ff, op_in;
   logic [bpba_pkg::TICKET_W-1:0] tkt_ff, tkt_in;
   logic [15:0]                   size_ff, size_in, align_ff, align_in;
   logic [31:0]                   base_ff, base_in;
   logic [OFF_W-1:0]              bs_ff, bs_in;
   logic [7:0]                    hdr_ff, hdr_in;
   logic [CNT_W-1:0]              fc_ff, fc_in, steps_ff, steps_in;
   logic [IDX_W-1:0]              clr_ff, clr_in, cur_ff, cur_in, blk_ff, blk_in;
   logic [IDX_W-1:0]              nb_ff, nb_in, last_ff, last_in, b_ff, b_in;
   logic [OFF_W-1:0]              off_ff, off_in;
   logic [31:0]                   prod_ff, prod_in, a_ff, a_in;
   logic [15:0]                   pad_ff, pad_in;
   logic [31:0]                   res_addr_ff, res_addr_in, out_addr_ff, out_addr_in;
   logic [7:0]                    res_hnd_ff, res_hnd_in, out_hnd_ff, out_hnd_in;
   logic [1:0]                    res_st_ff, res_st_in, out_st_ff, out_st_in;
   logic                          out_valid_ff, out_valid_in;

   logic             stk_we, tbl_we, chn_we;
   logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_rdata, tbl_waddr, chn_wdata, chn_rdata;
   logic [TBL_W-1:0] tbl_wdata, tbl_rdata;
   logic [IDX_W-1:0] tkt_idx, tbl_cur;
   logic [OFF_W-1:0] tbl_off;
   logic             push_en;
   logic [IDX_W-1:0] push_data;
   logic             rem_start, rem_done;
   logic [15:0]      rem_val, pad_calc;
   logic [18:0]      sum_cur;
   logic [17:0]      sum_fresh;

   bpba_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BLOCKS)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(IDX_W'(fc_ff - CNT_W'(1))), .rd_data(stk_rdata)
   );

   bpba_ram #(.WIDTH(TBL_W), .DEPTH(NUM_BLOCKS)) u_ticket (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
      .rd_addr(tkt_idx), .rd_data(tbl_rdata)
   );

   bpba_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BLOCKS)) u_chain (
      .clock(clock), .wr_en(chn_we), .wr_addr(cur_ff), .wr_data(chn_wdata),
      .rd_addr(b_ff), .rd_data(chn_rdata)
   );

   bpba_rem u_rem (
      .clock(clock), .reset(reset), .start(rem_start), .dividend(a_ff),
      .divisor(align_ff), .done(rem_done), .remainder(rem_val)
   );

   assign tkt_idx   = IDX_W'(tkt_ff);
   assign tbl_cur   = tbl_rdata[TBL_W-1 -: IDX_W];
   assign tbl_off   = tbl_rdata[OFF_W-1:0];
   assign sum_cur   = 19'(off_ff) + 19'(pad_ff) + 19'(size_ff);
   assign sum_fresh = 18'(pad_ff) + 18'(size_ff);
   assign pad_calc  = (align_ff == 16'd0 || rem_val == 16'd0) ? 16'd0 : align_ff - rem_val;

   always_comb begin
      status.op         = op_ff;
      status.fc_zero    = (fc_ff == CNT_W'(0));
      status.ticket_ok  = (32'(tkt_ff) < 32'(NUM_BLOCKS));
      status.rem_done   = rem_done;
      status.fits_cur   = (sum_cur <= 19'(bs_ff));
      status.fits_fresh = (sum_fresh <= 18'(bs_ff));
      status.walk_done  = (b_ff == last_ff) || (steps_ff >= CNT_W'(NUM_BLOCKS))
                          || (32'(b_ff) >= 32'(NUM_BLOCKS));
      status.clr_last   = (clr_ff == IDX_W'(NUM_BLOCKS - 1));
      status.out_busy   = out_valid_ff && !rsp_ready;
   end

   always_comb begin
      op_in = op_ff;  tkt_in = tkt_ff;  size_in = size_ff;  align_in = align_ff;
      base_in = base_ff;  bs_in = bs_ff;  hdr_in = hdr_ff;
      fc_in = fc_ff;  steps_in = steps_ff;  clr_in = clr_ff;
      cur_in = cur_ff;  blk_in = blk_ff;  nb_in = nb_ff;  last_in = last_ff;  b_in = b_ff;
      off_in = off_ff;  prod_in = prod_ff;  a_in = a_ff;  pad_in = pad_ff;
      res_addr_in = res_addr_ff;  res_hnd_in = res_hnd_ff;  res_st_in = res_st_ff;
      out_addr_in = out_addr_ff;  out_hnd_in = out_hnd_ff;  out_st_in = out_st_ff;
      out_valid_in = out_valid_ff;
      stk_we = 1'b0;  stk_waddr = clr_ff;  stk_wdata = clr_ff;
      tbl_we = 1'b0;  tbl_waddr = tkt_idx;  tbl_wdata = {cur_ff, off_ff};
      chn_we = 1'b0;  chn_wdata = nb_ff;
      push_en = 1'b0;  push_data = tkt_idx;
      rem_start = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            bpba_pkg::CSR_POOL_BASE:  base_in = csr_wdata;
            bpba_pkg::CSR_BLOCK_SIZE: bs_in   = OFF_W'(csr_wdata);
            bpba_pkg::CSR_HEADER:     hdr_in  = 8'(csr_wdata);
            default: ;
         endcase
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (cmd)
         bpba_pkg::CMD_LATCH: begin
            op_in = req_op;  tkt_in = req_ticket;  size_in = req_size;  align_in = req_align;
         end
         bpba_pkg::CMD_CLR_INIT: clr_in = '0;
         bpba_pkg::CMD_CLR_STEP: begin
            stk_we = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(NUM_BLOCKS - 1)) begin
               fc_in = CNT_W'(NUM_BLOCKS);
            end
         end
         bpba_pkg::CMD_TAKE: begin
            fc_in     = fc_ff - CNT_W'(1);
            tbl_we    = 1'b1;
            tbl_waddr = stk_rdata;
            tbl_wdata = {stk_rdata, OFF_W'(hdr_ff)};
            blk_in    = stk_rdata;
            off_in    = '0;
         end
         bpba_pkg::CMD_LOAD_CUR: begin
            cur_in = tbl_cur;  blk_in = tbl_cur;  off_in = tbl_off;
         end
         bpba_pkg::CMD_MUL:       prod_in = 32'(blk_ff) * 32'(bs_ff);
         bpba_pkg::CMD_ADD:       a_in = base_ff + prod_ff + 32'(off_ff);
         bpba_pkg::CMD_REM_START: rem_start = 1'b1;
         bpba_pkg::CMD_PAD:       pad_in = pad_calc;
         bpba_pkg::CMD_FRESH_LOAD: begin
            nb_in = stk_rdata;  blk_in = stk_rdata;  off_in = '0;
         end
         bpba_pkg::CMD_BUMP: begin
            tbl_we      = 1'b1;
            tbl_wdata   = {cur_ff, OFF_W'(sum_cur)};
            res_addr_in = a_ff + 32'(pad_ff);
            res_hnd_in  = 8'(cur_ff);
            res_st_in   = bpba_pkg::ST_OK;
         end
         bpba_pkg::CMD_FRESH: begin
            fc_in       = fc_ff - CNT_W'(1);
            chn_we      = 1'b1;
            tbl_we      = 1'b1;
            tbl_wdata   = {nb_ff, OFF_W'(sum_fresh)};
            res_addr_in = a_ff + 32'(pad_ff);
            res_hnd_in  = 8'(nb_ff);
            res_st_in   = bpba_pkg::ST_OK;
         end
         bpba_pkg::CMD_RES_CLEAR: begin
            res_addr_in = '0;  res_hnd_in = '0;  res_st_in = bpba_pkg::ST_OK;
         end
         bpba_pkg::CMD_RES_OOM: begin
            res_addr_in = '0;  res_hnd_in = '0;  res_st_in = bpba_pkg::ST_OOM;
         end
         bpba_pkg::CMD_RES_OOM_CUR: begin
            res_addr_in = '0;  res_hnd_in = 8'(cur_ff);  res_st_in = bpba_pkg::ST_OOM;
         end
         bpba_pkg::CMD_RES_BIG: begin
            res_addr_in = '0;  res_hnd_in = 8'(cur_ff);  res_st_in = bpba_pkg::ST_BIG;
         end
         bpba_pkg::CMD_TAKE_RES: begin
            res_addr_in = a_ff;  res_hnd_in = 8'(blk_ff);  res_st_in = bpba_pkg::ST_OK;
         end
         bpba_pkg::CMD_WALK_INIT: begin
            last_in  = tbl_cur;
            b_in     = tkt_idx;
            steps_in = '0;
            push_en  = 1'b1;
         end
         bpba_pkg::CMD_WALK_STEP: begin
            b_in = chn_rdata;
            if (32'(chn_rdata) < 32'(NUM_BLOCKS)) begin
               push_en   = 1'b1;
               push_data = chn_rdata;
               steps_in  = steps_ff + CNT_W'(1);
            end
         end
         bpba_pkg::CMD_RES_RET: begin
            res_addr_in = '0;  res_hnd_in = 8'(last_ff);  res_st_in = bpba_pkg::ST_OK;
         end
         bpba_pkg::CMD_EMIT: begin
            out_valid_in = 1'b1;
            out_addr_in  = res_addr_ff;
            out_hnd_in   = res_hnd_ff;
            out_st_in    = res_st_ff;
         end
         default: ;
      endcase

      if (push_en && fc_ff < CNT_W'(NUM_BLOCKS)) begin
         stk_we    = 1'b1;
         stk_waddr = IDX_W'(fc_ff);
         stk_wdata = push_data;
         fc_in     = fc_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= bpba_pkg::POOL_BASE_RST;
         bs_ff        <= bpba_pkg::BLOCK_SIZE_RST;
         hdr_ff       <= bpba_pkg::HEADER_RST;
         fc_ff        <= '0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         bs_ff        <= bs_in;
         hdr_ff       <= hdr_in;
         fc_ff        <= fc_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff <= op_in;  tkt_ff <= tkt_in;  size_ff <= size_in;  align_ff <= align_in;
      steps_ff <= steps_in;  cur_ff <= cur_in;  blk_ff <= blk_in;  nb_ff <= nb_in;
      last_ff <= last_in;  b_ff <= b_in;  off_ff <= off_in;  prod_ff <= prod_in;
      a_ff <= a_in;  pad_ff <= pad_in;
      res_addr_ff <= res_addr_in;  res_hnd_ff <= res_hnd_in;  res_st_ff <= res_st_in;
      out_addr_ff <= out_addr_in;  out_hnd_ff <= out_hnd_in;  out_st_ff <= out_st_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_address = out_addr_ff;
   assign rsp_handle  = out_hnd_ff;
   assign rsp_status  = out_st_ff;

endmodule

// File: hdl/bpba_ctrl.sv
module bpba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bpba_pkg::dp_status_type status,
   output bpba_pkg::dp_cmd_type    cmd
);

   bpba_pkg::state_type state_ff, state_in;
   logic                fresh_ff, fresh_in;
   logic                refill_ff, refill_in;

   always_comb begin
      state_in  = state_ff;
      fresh_in  = fresh_ff;
      refill_in = refill_ff;
      cmd       = bpba_pkg::CMD_NONE;
      req_ready = 1'b0;

      case (state_ff)
         bpba_pkg::S_CLEAR: begin
            cmd = bpba_pkg::CMD_CLR_STEP;
            if (status.clr_last) begin
               state_in  = refill_ff ? bpba_pkg::S_RF_RES : bpba_pkg::S_IDLE;
               refill_in = 1'b0;
            end
         end
         bpba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd       = bpba_pkg::CMD_LATCH;
            fresh_in  = 1'b0;
            if (req_valid) begin
               state_in = bpba_pkg::S_DISPATCH;
            end
         end
         bpba_pkg::S_DISPATCH: begin
            case (status.op)
               bpba_pkg::OP_TAKE: begin
                  if (status.fc_zero) begin
                     cmd      = bpba_pkg::CMD_RES_OOM;
                     state_in = bpba_pkg::S_FIN;
                  end else begin
                     state_in = bpba_pkg::S_TK_LOAD;
                  end
               end
               bpba_pkg::OP_ALLOC, bpba_pkg::OP_RETURN: begin
                  if (!status.ticket_ok) begin
                     cmd      = bpba_pkg::CMD_RES_CLEAR;
                     state_in = bpba_pkg::S_FIN;
                  end else if (status.op == bpba_pkg::OP_ALLOC) begin
                     state_in = bpba_pkg::S_AL_LOAD;
                  end else begin
                     state_in = bpba_pkg::S_RT_INIT;
                  end
               end
               default: begin
                  cmd       = bpba_pkg::CMD_CLR_INIT;
                  refill_in = 1'b1;
                  state_in  = bpba_pkg::S_CLEAR;
               end
            endcase
         end
         bpba_pkg::S_TK_LOAD: begin
            cmd      = bpba_pkg::CMD_TAKE;
            state_in = bpba_pkg::S_TK_MUL;
         end
         bpba_pkg::S_TK_MUL: begin
            cmd      = bpba_pkg::CMD_MUL;
            state_in = bpba_pkg::S_TK_ADD;
         end
         bpba_pkg::S_TK_ADD: begin
            cmd      = bpba_pkg::CMD_ADD;
            state_in = bpba_pkg::S_TK_RES;
         end
         bpba_pkg::S_TK_RES: begin
            cmd      = bpba_pkg::CMD_TAKE_RES;
            state_in = bpba_pkg::S_FIN;
         end
         bpba_pkg::S_AL_LOAD: begin
            cmd      = bpba_pkg::CMD_LOAD_CUR;
            state_in = bpba_pkg::S_A_MUL;
         end
         bpba_pkg::S_A_MUL: begin
            cmd      = bpba_pkg::CMD_MUL;
            state_in = bpba_pkg::S_A_ADD;
         end
         bpba_pkg::S_A_ADD: begin
            cmd      = bpba_pkg::CMD_ADD;
            state_in = bpba_pkg::S_A_REM;
         end
         bpba_pkg::S_A_REM: begin
            cmd      = bpba_pkg::CMD_REM_START;
            state_in = bpba_pkg::S_A_WAIT;
         end
         bpba_pkg::S_A_WAIT: begin
            if (status.rem_done) begin
               cmd      = bpba_pkg::CMD_PAD;
               state_in = bpba_pkg::S_A_CHECK;
            end
         end
         bpba_pkg::S_A_CHECK: begin
            state_in = bpba_pkg::S_FIN;
            if (fresh_ff) begin
               cmd = status.fits_fresh ? bpba_pkg::CMD_FRESH : bpba_pkg::CMD_RES_BIG;
            end else if (status.fits_cur) begin
               cmd = bpba_pkg::CMD_BUMP;
            end else if (status.fc_zero) begin
               cmd = bpba_pkg::CMD_RES_OOM_CUR;
            end else begin
               state_in = bpba_pkg::S_AL_FRESH;
            end
         end
         bpba_pkg::S_AL_FRESH: begin
            cmd      = bpba_pkg::CMD_FRESH_LOAD;
            fresh_in = 1'b1;
            state_in = bpba_pkg::S_A_MUL;
         end
         bpba_pkg::S_RT_INIT: begin
            cmd      = bpba_pkg::CMD_WALK_INIT;
            state_in = bpba_pkg::S_RT_CHECK;
         end
         bpba_pkg::S_RT_CHECK: begin
            if (status.walk_done) begin
               cmd      = bpba_pkg::CMD_RES_RET;
               state_in = bpba_pkg::S_FIN;
            end else begin
               state_in = bpba_pkg::S_RT_STEP;
            end
         end
         bpba_pkg::S_RT_STEP: begin
            cmd      = bpba_pkg::CMD_WALK_STEP;
            state_in = bpba_pkg::S_RT_CHECK;
         end
         bpba_pkg::S_RF_RES: begin
            cmd      = bpba_pkg::CMD_RES_CLEAR;
            state_in = bpba_pkg::S_FIN;
         end
         bpba_pkg::S_FIN: begin
            if (!status.out_busy) begin
               cmd      = bpba_pkg::CMD_EMIT;
               state_in = bpba_pkg::S_IDLE;
            end
         end
         default: state_in = bpba_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bpba_pkg::S_CLEAR;
         fresh_ff  <= 1'b0;
         refill_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fresh_ff  <= fresh_in;
         refill_ff <= refill_in;
      end
   end

endmodule

// File: hdl/block_pool_bump_allocator_top.sv
// fixed-size block pool with per-ticket aligned bump allocation
// request channel (req_): tuser carries the op (take, allocate, return, refill);
//   tdata carries ticket, size and alignment
// response channel (rsp_): one response per request; tdata carries address and
//   handle, tuser the status (ok, out of memory, larger than a block)
// csr_ port writes pool base, block size and header bytes; the user must write them
//   only while the block is idle, and the block itself does not enforce it
// requests are handled one at a time:
//   allocate that fits waits on the bit-serial remainder for the alignment padding
//   allocate that chains a fresh block runs two remainder passes
//   return walks the chain from the ticket's own block,
//     one chain memory read per block after it
//   refill rebuilds the free stack, one free-stack entry written per cycle
// after reset the free stack is rebuilt with req_tready low
// the response sits in an output register; a stalled receiver holds it there and
// the block keeps taking and working on the next request, waiting only to deliver
module block_pool_bump_allocator_top #(
   parameter int NUM_BLOCKS = bpba_pkg::NUM_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // ticket, size, alignment
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // address, handle
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   bpba_pkg::dp_cmd_type    cmd;
   bpba_pkg::dp_status_type status;
   logic [31:0]             rsp_address;
   logic [7:0]              rsp_handle;

   bpba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_tvalid), .req_ready(req_tready),
      .status(status), .cmd(cmd)
   );

   bpba_dp #(.NUM_BLOCKS(NUM_BLOCKS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_op(req_tuser), .req_ticket(req_tdata[7:0]), .req_size(req_tdata[23:8]),
      .req_align(req_tdata[39:24]),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_address(rsp_address),
      .rsp_handle(rsp_handle), .rsp_status(rsp_tuser)
   );

   assign rsp_tdata = {rsp_handle, rsp_address};

endmodule

// File: hdl/bpba_checker.sv
module bpba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == bpba_pkg::ST_OK || rsp_tuser == bpba_pkg::ST_OOM
                      || rsp_tuser == bpba_pkg::ST_BIG))
      else $error("undefined status code");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != bpba_pkg::ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("failed request with nonzero address");

   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_tready && !rsp_tvalid)
      else $error("request taken during free stack rebuild");

endmodule

bind block_pool_bump_allocator_top bpba_checker u_checker (.*);
